// ===== design/vlpe_pkg.sv =====
// ----------------------------------------------------------------------------
// vlpe_pkg
// Types, constants and prefix tables shared by the length-prefix encoder.
// ----------------------------------------------------------------------------
package vlpe_pkg;

  localparam int ValueW  = 64;
  localparam int ByteW   = 8;
  localparam int MaxLen  = 9;
  localparam int LenW    = 4;
  localparam int WordW   = MaxLen * ByteW;
  localparam int QDepth  = 2;
  localparam int QPtrW   = 1;
  localparam int QCntW   = 2;

  typedef logic [LenW-1:0]   len_t;
  typedef logic [WordW-1:0]  word_t;
  typedef logic [ValueW-1:0] value_t;
  typedef logic [ByteW-1:0]  byte_t;

  typedef struct packed {
    len_t  len;
    word_t word;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Ones of the unary prefix, placed above the zero bit at position 7L.
  function automatic value_t ones_mask(input len_t len);
    value_t m;
    m = '0;
    case (len)
      4'd2:    m = 64'h0000_0000_0000_8000;
      4'd3:    m = 64'h0000_0000_00C0_0000;
      4'd4:    m = 64'h0000_0000_E000_0000;
      4'd5:    m = 64'h0000_00F0_0000_0000;
      4'd6:    m = 64'h0000_F800_0000_0000;
      4'd7:    m = 64'h00FC_0000_0000_0000;
      4'd8:    m = 64'hFE00_0000_0000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Sign bit position 7L-1 in signed mode.
  function automatic value_t sign_mask(input len_t len);
    value_t m;
    m = '0;
    case (len)
      4'd1:    m = 64'h0000_0000_0000_0040;
      4'd2:    m = 64'h0000_0000_0000_2000;
      4'd3:    m = 64'h0000_0000_0010_0000;
      4'd4:    m = 64'h0000_0000_0800_0000;
      4'd5:    m = 64'h0000_0004_0000_0000;
      4'd6:    m = 64'h0000_0200_0000_0000;
      4'd7:    m = 64'h0001_0000_0000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/vlpe_if.sv =====
// ----------------------------------------------------------------------------
// vlpe_in_if / vlpe_out_if
// Valid/ready channels for input values and encoded bytes.
// ----------------------------------------------------------------------------
interface vlpe_in_if;
  logic                  valid;
  logic                  ready;
  vlpe_pkg::value_t      value;
  logic                  signed_mode;

  modport source (output valid, output value, output signed_mode, input ready);
  modport sink   (input valid, input value, input signed_mode, output ready);
endinterface

interface vlpe_out_if;
  logic                  valid;
  logic                  ready;
  vlpe_pkg::byte_t       out_byte;
  logic                  last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== design/vlpe_front.sv =====
// ----------------------------------------------------------------------------
// vlpe_front
// Classify a value: pick the byte count and build the encoded word.
// ----------------------------------------------------------------------------
module vlpe_front (
  input  vlpe_pkg::value_t value_i,
  input  logic             signed_mode_i,
  output vlpe_pkg::entry_t entry_o
);
  import vlpe_pkg::*;

  logic   neg;
  value_t payload;
  len_t   len;
  byte_t  head;

  always_comb begin
    neg     = signed_mode_i & value_i[ValueW-1];
    payload = neg ? (~value_i + value_t'(1)) : value_i;
    len     = len_t'(MaxLen);
    if (signed_mode_i) begin
      for (int l = 7; l >= 1; l--) begin
        if ((payload >> (7 * l - 1)) == '0) begin
          len = len_t'(l);
        end
      end
    end else begin
      for (int l = 8; l >= 1; l--) begin
        if ((payload >> (7 * l)) == '0) begin
          len = len_t'(l);
        end
      end
    end
  end

  always_comb begin
    head          = signed_mode_i ? {7'h7F, neg} : 8'hFF;
    entry_o.len   = len;
    if (len == len_t'(MaxLen)) begin
      entry_o.word = {head, payload};
    end else begin
      entry_o.word = {byte_t'(0),
                      payload | ones_mask(len) | (neg ? sign_mask(len) : value_t'(0))};
    end
  end

endmodule

// ===== design/vlpe_queue.sv =====
// ----------------------------------------------------------------------------
// vlpe_queue
// Two-entry queue between classifier and byte serialiser.
// ----------------------------------------------------------------------------
module vlpe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vlpe_pkg::entry_t    entry_i,
  input  logic                pop_i,
  output vlpe_pkg::entry_t    head_o,
  output vlpe_pkg::q_status_t status_o
);
  import vlpe_pkg::*;

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d;
  logic [QPtrW-1:0]   rd_q, rd_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== design/vlpe_back.sv =====
// ----------------------------------------------------------------------------
// vlpe_back
// Serialise the queue head into bytes, most significant first.
// ----------------------------------------------------------------------------
module vlpe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vlpe_pkg::entry_t    head_i,
  input  vlpe_pkg::q_status_t status_i,
  output logic                pop_o,
  vlpe_out_if.source          out_o
);
  import vlpe_pkg::*;

  len_t  cnt_q, cnt_d;
  logic  valid_q, valid_d;
  byte_t byte_q, byte_d;
  logic  last_q, last_d;
  logic  fire;
  logic  at_last;
  len_t  sel;
  byte_t bytes [MaxLen];

  always_comb begin
    for (int i = 0; i < MaxLen; i++) begin
      bytes[i] = head_i.word[i*ByteW +: ByteW];
    end
  end

  always_comb begin
    fire    = !status_i.empty && (!valid_q || out_o.ready);
    sel     = head_i.len - len_t'(1) - cnt_q;
    at_last = (cnt_q == head_i.len - len_t'(1));
    pop_o   = fire && at_last;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (fire) begin
      valid_d = 1'b1;
      byte_d  = bytes[sel];
      last_d  = at_last;
      cnt_d   = at_last ? len_t'(0) : cnt_q + len_t'(1);
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.last_byte = last_q;

endmodule

// ===== design/varint_length_prefix_encoder.sv =====
// ----------------------------------------------------------------------------
// varint_length_prefix_encoder
// Unary length-prefix varint encoder, one output byte per cycle while out_o is ready.
// ----------------------------------------------------------------------------
// Each accepted value becomes 1 to 9 bytes on out_o, most significant first,
// with last_byte on the final one. The byte serialiser emits one byte a cycle
// while out_o is ready; values are classified on entry and held in a
// two-entry queue, so input keeps flowing while earlier values are still
// being sent. Each value is registered in the queue, and then each of its
// bytes in the output byte register.
module varint_length_prefix_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  vlpe_in_if.sink    in_i,
  vlpe_out_if.source out_o
);
  import vlpe_pkg::*;

  entry_t    entry;
  entry_t    head;
  q_status_t q_stat;
  logic      push;
  logic      pop;

  assign in_i.ready = !q_stat.full;
  assign push       = in_i.valid && !q_stat.full;

  vlpe_front u_front (
    .value_i       (in_i.value),
    .signed_mode_i (in_i.signed_mode),
    .entry_o       (entry)
  );

  vlpe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_stat)
  );

  vlpe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .status_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat.empty |-> (head.len != '0 && head.len <= len_t'(MaxLen)))
    else $error("queued length out of range");

  a_pop_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (out_o.valid && out_o.last_byte))
    else $error("item retired without last byte");

  a_short_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && entry.len != len_t'(MaxLen) |-> entry.word[WordW-1 -: ByteW] == '0)
    else $error("short encoding has stray top byte");
`endif

endmodule
